>>> rtl/core/kcch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kcch_pkg;

  localparam int MAX_KMER    = 10;
  localparam int KSIZE_W     = 4;
  localparam int KMER_W      = 2 * MAX_KMER;
  localparam int TABLE_AW    = KMER_W;
  localparam int TABLE_DEPTH = 1 << TABLE_AW;
  localparam int COUNT_W     = 8;
  localparam int HIST_AW     = 8;
  localparam int HIST_W      = 40;
  localparam int TOTAL_W     = 48;
  localparam int DIST_W      = 21;
  localparam int BASES_W     = 5;
  localparam int INDEX_W     = 20;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
  localparam logic [BASES_W-1:0] BASES_MAX = 5'd31;

  typedef enum logic [1:0] {
    OP_BASE    = 2'd0,
    OP_MERGE   = 2'd1,
    OP_RD_HIST = 2'd2,
    OP_RD_TAB  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_SUMMARY = 2'd0,
    KIND_HIST    = 2'd1,
    KIND_ENTRY   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         base_char;
    logic               read_start;
    logic [INDEX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [TOTAL_W-1:0] value;
    logic [DIST_W-1:0]  distinct;
  } rsp_t;

  typedef struct packed {
    op_e                 op;
    logic [TABLE_AW-1:0] addr;
  } task_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_INC,
    B_HIST_OUT,
    B_TAB_OUT,
    M_RD_I,
    M_CHK_I,
    M_CHK_RC,
    M_CLR_RC,
    M_HIST_RD,
    M_HIST_WR,
    M_DONE
  } back_state_e;

  function automatic logic [KSIZE_W-1:0] eff_k(input logic [KSIZE_W-1:0] ksize);
    logic [KSIZE_W-1:0] k;
    k = ksize;
    if (k == '0) k = KSIZE_W'(1);
    if (k > KSIZE_W'(MAX_KMER)) k = KSIZE_W'(MAX_KMER);
    return k;
  endfunction

  function automatic logic [KMER_W-1:0] kmer_mask(input logic [KSIZE_W-1:0] k);
    logic [KMER_W-1:0] m;
    m = '0;
    for (int j = 0; j < KMER_W; j++) begin
      m[j] = (j < 2 * int'(k));
    end
    return m;
  endfunction

  function automatic logic [1:0] base_code(input logic [7:0] c);
    logic [1:0] code;
    case (c)
      8'h43:   code = 2'd1;
      8'h47:   code = 2'd2;
      8'h54:   code = 2'd3;
      default: code = 2'd0;
    endcase
    return code;
  endfunction

  function automatic logic [KMER_W-1:0] rev_comp(input logic [KMER_W-1:0] x,
                                                 input logic [KSIZE_W-1:0] k);
    logic [KMER_W-1:0] r;
    r = '0;
    for (int j = 0; j < MAX_KMER; j++) begin
      for (int i = 0; i < MAX_KMER; i++) begin
        if ((j < int'(k)) && (i == int'(k) - 1 - j)) begin
          r[2*j +: 2] = ~x[2*i +: 2];
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/kcch_front.sv
`timescale 1ns / 1ps
`default_nettype none

module kcch_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire kcch_pkg::req_t                     req,
  input  wire logic [kcch_pkg::KSIZE_W-1:0]       k_eff,
  output logic                                    push,
  output kcch_pkg::task_t                         task_out,
  output logic [kcch_pkg::TOTAL_W-1:0]            total
);

  logic [kcch_pkg::KMER_W-1:0]  rolling;
  logic [kcch_pkg::KMER_W-1:0]  rolling_next;
  logic [kcch_pkg::BASES_W-1:0] bases;
  logic [kcch_pkg::BASES_W-1:0] bases_next;
  logic [kcch_pkg::TOTAL_W-1:0] total_next;
  logic                         merged;
  logic                         merged_next;
  logic [kcch_pkg::KMER_W-1:0]  rk0;
  logic [kcch_pkg::BASES_W-1:0] bir0;
  logic [kcch_pkg::KMER_W-1:0]  rk_new;
  logic [kcch_pkg::BASES_W-1:0] bir_new;
  logic                         counts;

  always_comb begin
    rk0     = req.read_start ? '0 : rolling;
    bir0    = req.read_start ? '0 : bases;
    rk_new  = {rk0[kcch_pkg::KMER_W-3:0], kcch_pkg::base_code(req.base_char)}
              & kcch_pkg::kmer_mask(k_eff);
    bir_new = (bir0 < kcch_pkg::BASES_MAX) ? bir0 + 1'b1 : kcch_pkg::BASES_MAX;
    counts  = (bir_new >= {1'b0, k_eff});

    rolling_next  = rolling;
    bases_next    = bases;
    total_next    = total;
    merged_next   = merged;
    push          = 1'b0;
    task_out.op   = kcch_pkg::op_e'(req.opcode);
    task_out.addr = req.index;

    if (accept) begin
      case (req.opcode)
        kcch_pkg::OP_BASE: begin
          if (!merged) begin
            rolling_next  = rk_new;
            bases_next    = bir_new;
            task_out.addr = rk_new;
            if (counts) begin
              push = 1'b1;
              if (total != {kcch_pkg::TOTAL_W{1'b1}}) total_next = total + 1'b1;
            end
          end
        end
        kcch_pkg::OP_MERGE: begin
          push        = 1'b1;
          merged_next = 1'b1;
        end
        default: begin
          push = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rolling <= '0;
      bases   <= '0;
      total   <= '0;
      merged  <= 1'b0;
    end else begin
      rolling <= rolling_next;
      bases   <= bases_next;
      total   <= total_next;
      merged  <= merged_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/kcch_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module kcch_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire kcch_pkg::task_t push_data,
  input  wire logic            pop,
  output kcch_pkg::task_t      head,
  output logic                 full,
  output logic                 empty
);

  kcch_pkg::task_t                entries [kcch_pkg::QUEUE_DEPTH];
  logic [kcch_pkg::QUEUE_AW-1:0]  wptr;
  logic [kcch_pkg::QUEUE_AW-1:0]  rptr;
  logic [kcch_pkg::QUEUE_AW:0]    cnt;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (cnt == (kcch_pkg::QUEUE_AW + 1)'(kcch_pkg::QUEUE_DEPTH));
  assign empty   = (cnt == '0);
  assign head    = entries[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/kcch_back.sv
`timescale 1ns / 1ps
`default_nettype none

module kcch_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [kcch_pkg::KSIZE_W-1:0]  k_eff,
  input  wire kcch_pkg::task_t               head,
  input  wire logic                          empty,
  input  wire logic [kcch_pkg::TOTAL_W-1:0]  total,
  output logic                               pop,
  output logic                               ready,
  output logic                               done,
  output kcch_pkg::rsp_t                     rsp
);

  logic [kcch_pkg::COUNT_W-1:0] tab_mem [kcch_pkg::TABLE_DEPTH];
  logic [kcch_pkg::HIST_W-1:0]  hist_mem [1 << kcch_pkg::HIST_AW];

  logic                          tab_we;
  logic [kcch_pkg::TABLE_AW-1:0] tab_waddr;
  logic [kcch_pkg::COUNT_W-1:0]  tab_wdata;
  logic [kcch_pkg::TABLE_AW-1:0] tab_raddr;
  logic [kcch_pkg::COUNT_W-1:0]  tab_q;
  logic                          hist_we;
  logic [kcch_pkg::HIST_AW-1:0]  hist_waddr;
  logic [kcch_pkg::HIST_W-1:0]   hist_wdata;
  logic [kcch_pkg::HIST_AW-1:0]  hist_raddr;
  logic [kcch_pkg::HIST_W-1:0]   hist_q;

  kcch_pkg::back_state_e         state;
  kcch_pkg::back_state_e         state_next;
  logic [kcch_pkg::TABLE_AW-1:0] clr;
  logic [kcch_pkg::TABLE_AW-1:0] clr_next;
  logic [kcch_pkg::TABLE_AW-1:0] inc_addr;
  logic [kcch_pkg::TABLE_AW-1:0] inc_addr_next;
  logic                          fwd;
  logic                          fwd_next;
  logic [kcch_pkg::COUNT_W-1:0]  wlast;
  logic [kcch_pkg::COUNT_W-1:0]  wlast_next;
  logic [kcch_pkg::TABLE_AW-1:0] walk_i;
  logic [kcch_pkg::TABLE_AW-1:0] walk_i_next;
  logic [kcch_pkg::TABLE_AW-1:0] rc;
  logic [kcch_pkg::TABLE_AW-1:0] rc_next;
  logic [kcch_pkg::COUNT_W-1:0]  cur;
  logic [kcch_pkg::COUNT_W-1:0]  cur_next;
  logic [kcch_pkg::COUNT_W-1:0]  add;
  logic [kcch_pkg::COUNT_W-1:0]  add_next;
  logic [kcch_pkg::DIST_W-1:0]   distinct;
  logic [kcch_pkg::DIST_W-1:0]   distinct_next;
  logic                          merged;
  logic                          merged_next;
  logic                          done_next;
  kcch_pkg::rsp_t                rsp_next;

  logic [kcch_pkg::COUNT_W-1:0]  inc_cur;
  logic [kcch_pkg::TABLE_AW-1:0] rc_calc;
  logic [kcch_pkg::COUNT_W:0]    pair_sum;
  logic                          walk_last;
  kcch_pkg::rsp_t                summary;

  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    tab_q <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_q <= hist_mem[hist_raddr];
  end

  assign ready = (state != kcch_pkg::B_CLEAR);

  always_comb begin
    inc_cur   = fwd ? wlast : tab_q;
    rc_calc   = kcch_pkg::rev_comp(walk_i, k_eff);
    pair_sum  = {1'b0, cur} + {1'b0, tab_q};
    walk_last = (walk_i == kcch_pkg::kmer_mask(k_eff));

    summary.kind     = kcch_pkg::KIND_SUMMARY;
    summary.value    = total;
    summary.distinct = distinct;

    state_next    = state;
    clr_next      = clr;
    inc_addr_next = inc_addr;
    fwd_next      = fwd;
    wlast_next    = wlast;
    walk_i_next   = walk_i;
    rc_next       = rc;
    cur_next      = cur;
    add_next      = add;
    distinct_next = distinct;
    merged_next   = merged;
    done_next     = 1'b0;
    rsp_next      = rsp;
    pop           = 1'b0;

    tab_we     = 1'b0;
    tab_waddr  = inc_addr;
    tab_wdata  = '0;
    tab_raddr  = head.addr;
    hist_we    = 1'b0;
    hist_waddr = add;
    hist_wdata = hist_q + 1'b1;
    hist_raddr = head.addr[kcch_pkg::HIST_AW-1:0];

    case (state)
      kcch_pkg::B_CLEAR: begin
        tab_we     = 1'b1;
        tab_waddr  = clr;
        tab_wdata  = '0;
        hist_we    = (clr[kcch_pkg::TABLE_AW-1:kcch_pkg::HIST_AW] == '0);
        hist_waddr = clr[kcch_pkg::HIST_AW-1:0];
        hist_wdata = '0;
        clr_next   = clr + 1'b1;
        if (clr == {kcch_pkg::TABLE_AW{1'b1}}) state_next = kcch_pkg::B_IDLE;
      end

      kcch_pkg::B_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          case (head.op)
            kcch_pkg::OP_BASE: begin
              inc_addr_next = head.addr;
              fwd_next      = 1'b0;
              state_next    = kcch_pkg::B_INC;
            end
            kcch_pkg::OP_MERGE: begin
              if (merged) begin
                done_next = 1'b1;
                rsp_next  = summary;
              end else begin
                walk_i_next   = '0;
                distinct_next = '0;
                state_next    = kcch_pkg::M_RD_I;
              end
            end
            kcch_pkg::OP_RD_HIST: state_next = kcch_pkg::B_HIST_OUT;
            default:              state_next = kcch_pkg::B_TAB_OUT;
          endcase
        end
      end

      kcch_pkg::B_INC: begin
        tab_we     = 1'b1;
        tab_waddr  = inc_addr;
        tab_wdata  = (inc_cur == kcch_pkg::COUNT_MAX) ? kcch_pkg::COUNT_MAX
                                                      : inc_cur + 1'b1;
        wlast_next = tab_wdata;
        if (!empty && head.op == kcch_pkg::OP_BASE) begin
          pop           = 1'b1;
          fwd_next      = (head.addr == inc_addr);
          inc_addr_next = head.addr;
        end else begin
          state_next = kcch_pkg::B_IDLE;
        end
      end

      kcch_pkg::B_HIST_OUT: begin
        done_next         = 1'b1;
        rsp_next.kind     = kcch_pkg::KIND_HIST;
        rsp_next.value    = kcch_pkg::TOTAL_W'(hist_q);
        rsp_next.distinct = '0;
        state_next        = kcch_pkg::B_IDLE;
      end

      kcch_pkg::B_TAB_OUT: begin
        done_next         = 1'b1;
        rsp_next.kind     = kcch_pkg::KIND_ENTRY;
        rsp_next.value    = kcch_pkg::TOTAL_W'(tab_q);
        rsp_next.distinct = '0;
        state_next        = kcch_pkg::B_IDLE;
      end

      kcch_pkg::M_RD_I: begin
        tab_raddr  = walk_i;
        state_next = kcch_pkg::M_CHK_I;
      end

      kcch_pkg::M_CHK_I: begin
        cur_next  = tab_q;
        rc_next   = rc_calc;
        tab_raddr = rc_calc;
        if (tab_q == '0) begin
          walk_i_next = walk_i + 1'b1;
          state_next  = walk_last ? kcch_pkg::M_DONE : kcch_pkg::M_RD_I;
        end else if (walk_i < rc_calc) begin
          state_next = kcch_pkg::M_CHK_RC;
        end else begin
          add_next   = tab_q;
          state_next = kcch_pkg::M_HIST_RD;
        end
      end

      kcch_pkg::M_CHK_RC: begin
        if (tab_q != '0) begin
          add_next   = pair_sum[kcch_pkg::COUNT_W] ? kcch_pkg::COUNT_MAX
                                                   : pair_sum[kcch_pkg::COUNT_W-1:0];
          tab_we     = 1'b1;
          tab_waddr  = walk_i;
          tab_wdata  = add_next;
          state_next = kcch_pkg::M_CLR_RC;
        end else begin
          add_next   = cur;
          state_next = kcch_pkg::M_HIST_RD;
        end
      end

      kcch_pkg::M_CLR_RC: begin
        tab_we     = 1'b1;
        tab_waddr  = rc;
        tab_wdata  = '0;
        state_next = kcch_pkg::M_HIST_RD;
      end

      kcch_pkg::M_HIST_RD: begin
        hist_raddr = add;
        state_next = kcch_pkg::M_HIST_WR;
      end

      kcch_pkg::M_HIST_WR: begin
        hist_we       = 1'b1;
        hist_waddr    = add;
        hist_wdata    = hist_q + 1'b1;
        distinct_next = distinct + 1'b1;
        walk_i_next   = walk_i + 1'b1;
        state_next    = walk_last ? kcch_pkg::M_DONE : kcch_pkg::M_RD_I;
      end

      kcch_pkg::M_DONE: begin
        merged_next = 1'b1;
        done_next   = 1'b1;
        rsp_next    = summary;
        state_next  = kcch_pkg::B_IDLE;
      end

      default: begin
        state_next = kcch_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kcch_pkg::B_CLEAR;
      clr      <= '0;
      fwd      <= 1'b0;
      distinct <= '0;
      merged   <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr      <= clr_next;
      fwd      <= fwd_next;
      distinct <= distinct_next;
      merged   <= merged_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    inc_addr <= inc_addr_next;
    wlast    <= wlast_next;
    walk_i   <= walk_i_next;
    rc       <= rc_next;
    cur      <= cur_next;
    add      <= add_next;
    rsp      <= rsp_next;
  end

endmodule

`default_nettype wire

>>> rtl/core/kmer_count_canonical_histogram.sv
// channel   signals                          transfer
// request   start, busy, req                 start && !busy
// result    done, rsp                        done (one cycle, no backpressure)
// config    cfg_valid, cfg_ready, cfg_data   cfg_valid && cfg_ready
//
// a base is classified in the cycle it is taken; counted bases reach the table
// one per cycle while the queue holds them (read-modify-write, bypassed for a
// repeated address; the table has separate read and write ports)
// merge walks 4^k entries, folds reverse-complement pairs and bins each count
// reads answer from a registered output state; busy while the 4-entry queue is full
// after reset a clearing pass over all 1048576 table entries holds busy high
`timescale 1ns / 1ps
`default_nettype none

module kmer_count_canonical_histogram (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire kcch_pkg::req_t                req,
  output logic                               done,
  output kcch_pkg::rsp_t                     rsp,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [kcch_pkg::KSIZE_W-1:0]  cfg_data
);

  logic [kcch_pkg::KSIZE_W-1:0] kmer_size;
  logic [kcch_pkg::KSIZE_W-1:0] k_eff;
  logic                         accept;
  logic                         push;
  kcch_pkg::task_t              push_task;
  kcch_pkg::task_t              head;
  logic                         full;
  logic                         empty;
  logic                         pop;
  logic                         ready;
  logic [kcch_pkg::TOTAL_W-1:0] total;

  assign cfg_ready = 1'b1;
  assign k_eff     = kcch_pkg::eff_k(kmer_size);
  assign busy      = full || !ready;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_size <= kcch_pkg::KSIZE_W'(kcch_pkg::MAX_KMER);
    end else if (cfg_valid && cfg_ready) begin
      kmer_size <= cfg_data;
    end
  end

  kcch_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req      (req),
    .k_eff    (k_eff),
    .push     (push),
    .task_out (push_task),
    .total    (total)
  );

  kcch_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_task),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  kcch_back u_back (
    .clk   (clk),
    .rst   (rst),
    .k_eff (k_eff),
    .head  (head),
    .empty (empty),
    .total (total),
    .pop   (pop),
    .ready (ready),
    .done  (done),
    .rsp   (rsp)
  );

endmodule

`default_nettype wire

>>> rtl/core/kcch_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module kcch_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           busy,
  input wire logic           done,
  input wire kcch_pkg::rsp_t rsp
);

  // clearing pass holds off requests right after reset
  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> busy)
    else $error("not busy after reset");

  a_kind_valid: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.kind == kcch_pkg::KIND_SUMMARY || rsp.kind == kcch_pkg::KIND_HIST ||
              rsp.kind == kcch_pkg::KIND_ENTRY))
    else $error("bad result kind");

  a_distinct_summary_only: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.kind != kcch_pkg::KIND_SUMMARY) |-> (rsp.distinct == '0))
    else $error("distinct set on a read result");

  a_entry_width: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.kind == kcch_pkg::KIND_ENTRY) |->
      (rsp.value[kcch_pkg::TOTAL_W-1:kcch_pkg::COUNT_W] == '0))
    else $error("table entry wider than a counter");

  a_hist_width: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.kind == kcch_pkg::KIND_HIST) |->
      (rsp.value[kcch_pkg::TOTAL_W-1:kcch_pkg::HIST_W] == '0))
    else $error("histogram bin wider than its store");

endmodule

bind kmer_count_canonical_histogram kcch_checker u_kcch_checker (
  .clk  (clk),
  .rst  (rst),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);

`default_nettype wire
